// File: rtl/sacc_pkg.sv
// ----------------------------------------------------------------------------
// sacc_pkg: shared types and constants for the segment access checker
// Field widths, reciprocal decode constants and command codes.
// ----------------------------------------------------------------------------
package sacc_pkg;

	localparam int unsigned FIELD_W     = 10;
	localparam int unsigned OP_W        = 30;
	localparam int unsigned PROC_IN_W   = 8;
	localparam int unsigned KB_W        = 20;
	localparam int unsigned KB_SHIFT    = 10;
	localparam int unsigned ID_Q_W      = 11;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 32;

	// identifier = ((op >> 6) * ceil(2^38 / 15625)) >> 38, exact for op below 2^30
	localparam int unsigned ID_PRE_SHIFT   = 6;
	localparam int unsigned ID_PROD_W      = 49;
	localparam int unsigned ID_RECIP_SHIFT = 38;
	localparam logic [24:0] ID_RECIP       = 25'd17592187;
	localparam int unsigned ID_BACK_W      = 31;
	localparam logic [19:0] ID_SCALE       = 20'd1000000;

	// remainder after the identifier is below 10^6
	localparam int unsigned REM_W = 20;

	// base = ((rem >> 3) * ceil(2^24 / 125)) >> 24, exact for rem below 2^20
	localparam int unsigned BASE_PRE_SHIFT   = 3;
	localparam int unsigned BASE_PROD_W      = 35;
	localparam int unsigned BASE_RECIP_SHIFT = 24;
	localparam logic [17:0] BASE_RECIP       = 18'd134218;
	localparam int unsigned BASE_BACK_W      = 20;
	localparam logic [9:0]  BASE_SCALE       = 10'd1000;

	localparam logic [FIELD_W-1:0] FIELD_MAX = 10'd1023;
	localparam logic [KB_W-1:0]    KB_RESET  = 20'hFFFFF;
	localparam logic [FIELD_W-1:0] FIELD_LIMIT = 10'd999;

	typedef enum logic {
		CMD_ALLOC  = 1'b0,
		CMD_ACCESS = 1'b1
	} cmd_t;

endpackage

// File: rtl/sacc_ram.sv
// ----------------------------------------------------------------------------
// sacc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sacc_ram #(
	parameter int WIDTH = 38,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/segment_alloc_access_checker.sv
// ----------------------------------------------------------------------------
// segment_alloc_access_checker: segment table allocate / access check
// Decodes a packed decimal request, scans the segment table held in RAM
// and reports success or segmentation fault per transaction.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | payload
//  cfg       | in  | cfg_valid/cfg_ready   | cfg_data = mem_available_kb
//  s_axis    | in  | tvalid/tready         | tuser = cmd; tdata = process_num, op_value
//  m_axis    | out | tvalid/tready         | tuser = outcome; tdata = id, base, offset
//
//  One request at a time: accept, then the decode states ID_QUOT, ID_REM,
//  BASE_QUOT and BASE_REM (identifier, then base, each by reciprocal
//  multiplication followed by a multiply-subtract), then a scan of the table
//  RAM (one entry per cycle, read data registered), then retire.
//  Reset clears the fill count; entries at or above it are never read.
//  A stalled result sits in the output register; decoding of the next
//  request proceeds and only its retire cycle waits for m_axis_tready.
// ----------------------------------------------------------------------------
module segment_alloc_access_checker #(
	parameter int TABLE_DEPTH = 16,
	parameter int PROC_BITS   = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sacc_pkg::KB_W-1:0]          cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [sacc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // process_num, op_value, pad
	input  logic [0:0]                         s_axis_tuser,   // cmd
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [sacc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // seg_identifier, seg_base, seg_offset, pad
	output logic [0:0]                         m_axis_tuser    // outcome
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int FW = sacc_pkg::FIELD_W;
	localparam int EW = PROC_BITS + 3 * FW;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ID_QUOT,
		ST_ID_REM,
		ST_BASE_QUOT,
		ST_BASE_REM,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                          state_q;
	sacc_pkg::cmd_t                  cmd_q;
	logic [PROC_BITS-1:0]            proc_q;
	logic [sacc_pkg::OP_W-1:0]       rem_q;
	logic [sacc_pkg::ID_Q_W-1:0]     qid_q;
	logic [FW-1:0]                   base_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   rd_ptr_q;
	logic                            rvalid_s1;
	logic                            conflict_q;
	logic                            hit_q;
	logic                            ok_q;
	logic [sacc_pkg::KB_W-1:0]       mem_kb_q;
	logic                            out_valid_q;
	logic                            out_fault_q;
	logic [3*FW-1:0]                 out_data_q;

	logic [FW-1:0]                      ident_w;
	logic [FW-1:0]                      offset_w;
	logic [sacc_pkg::ID_PROD_W-1:0]     id_prod;
	logic [sacc_pkg::ID_BACK_W-1:0]     id_back;
	logic [sacc_pkg::BASE_PROD_W-1:0]   base_prod;
	logic [sacc_pkg::BASE_BACK_W-1:0]   base_back;
	logic [EW-1:0]        rd_data;
	logic [EW-1:0]        wr_data;
	logic [PROC_BITS-1:0] e_proc;
	logic [FW-1:0]        e_ident;
	logic [FW-1:0]        e_base;
	logic [FW-1:0]        e_offset;
	logic                 issue_done;
	logic                 rd_en;
	logic                 out_free;
	logic                 bad_alloc;
	logic                 fault;
	logic                 wr_en;

	// quotient above 1023 only when its top bit is set
	assign ident_w  = qid_q[sacc_pkg::ID_Q_W-1] ? sacc_pkg::FIELD_MAX : qid_q[FW-1:0];
	assign offset_w = rem_q[FW-1:0];

	assign id_prod   = rem_q[sacc_pkg::OP_W-1:sacc_pkg::ID_PRE_SHIFT] * sacc_pkg::ID_RECIP;
	assign id_back   = qid_q * sacc_pkg::ID_SCALE;
	assign base_prod = rem_q[sacc_pkg::REM_W-1:sacc_pkg::BASE_PRE_SHIFT]
		* sacc_pkg::BASE_RECIP;
	assign base_back = base_q * sacc_pkg::BASE_SCALE;

	assign e_offset = rd_data[FW-1:0];
	assign e_base   = rd_data[2*FW-1:FW];
	assign e_ident  = rd_data[3*FW-1:2*FW];
	assign e_proc   = rd_data[EW-1:3*FW];

	assign issue_done = (rd_ptr_q == count_q);
	assign rd_en      = (state_q == ST_SCAN) && !issue_done;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign bad_alloc  = conflict_q
		|| (base_q > mem_kb_q[sacc_pkg::KB_W-1:sacc_pkg::KB_SHIFT])
		|| (count_q >= DEPTH_C);
	assign fault   = (cmd_q == sacc_pkg::CMD_ALLOC) ? bad_alloc : !(hit_q && ok_q);
	assign wr_en   = (state_q == ST_DONE) && out_free && (cmd_q == sacc_pkg::CMD_ALLOC)
		&& !bad_alloc;
	assign wr_data = {proc_q, ident_w, base_q, offset_w};

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_fault_q;
	assign m_axis_tdata  = {{(sacc_pkg::OUT_TDATA_W - 3 * FW){1'b0}}, out_data_q};

	sacc_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= sacc_pkg::CMD_ALLOC;
			proc_q      <= '0;
			rem_q       <= '0;
			qid_q       <= '0;
			base_q      <= '0;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			rvalid_s1   <= 1'b0;
			conflict_q  <= 1'b0;
			hit_q       <= 1'b0;
			ok_q        <= 1'b0;
			mem_kb_q    <= sacc_pkg::KB_RESET;
			out_valid_q <= 1'b0;
			out_fault_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_valid) begin
				mem_kb_q <= cfg_data;
			end
			// retire reloads the output itself
			if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q   <= sacc_pkg::cmd_t'(s_axis_tuser[0]);
						proc_q  <= PROC_BITS'(s_axis_tdata[sacc_pkg::PROC_IN_W-1:0]);
						rem_q   <= s_axis_tdata[sacc_pkg::PROC_IN_W +: sacc_pkg::OP_W];
						qid_q   <= '0;
						base_q  <= '0;
						state_q <= ST_ID_QUOT;
					end
				end
				ST_ID_QUOT: begin
					qid_q   <= id_prod[sacc_pkg::ID_RECIP_SHIFT +: sacc_pkg::ID_Q_W];
					state_q <= ST_ID_REM;
				end
				ST_ID_REM: begin
					rem_q   <= rem_q - id_back[sacc_pkg::OP_W-1:0];
					state_q <= ST_BASE_QUOT;
				end
				ST_BASE_QUOT: begin
					base_q  <= base_prod[sacc_pkg::BASE_RECIP_SHIFT +: FW];
					state_q <= ST_BASE_REM;
				end
				ST_BASE_REM: begin
					rem_q      <= rem_q
						- {{(sacc_pkg::OP_W - sacc_pkg::BASE_BACK_W){1'b0}}, base_back};
					rd_ptr_q   <= '0;
					rvalid_s1  <= 1'b0;
					conflict_q <= 1'b0;
					hit_q      <= 1'b0;
					ok_q       <= 1'b0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!issue_done) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					rvalid_s1 <= !issue_done;
					if (rvalid_s1) begin
						if ((e_base == base_q) || ((e_proc == proc_q) && (e_ident == ident_w))) begin
							conflict_q <= 1'b1;
						end
						// access: only the first full match decides
						if (!hit_q && (e_proc == proc_q) && (e_base == base_q)
								&& (e_ident == ident_w)) begin
							hit_q <= 1'b1;
							ok_q  <= (offset_w <= e_offset);
						end
					end
					if (issue_done && !rvalid_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_fault_q <= fault;
						out_data_q  <= {base_q, ident_w, offset_w} == '0 ? '0 :
							{offset_w, base_q, ident_w};
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/sacc_chk.sv
// ----------------------------------------------------------------------------
// sacc_chk: port-level checks for segment_alloc_access_checker
// Watches the stream ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sacc_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_valid,
	input logic                               cfg_ready,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [sacc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic [0:0]                         m_axis_tuser
);

	localparam int FW = sacc_pkg::FIELD_W;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// decoded base and offset are decimal digits groups
	a_fields_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2*FW-1:FW] <= sacc_pkg::FIELD_LIMIT)
			&& (m_axis_tdata[3*FW-1:2*FW] <= sacc_pkg::FIELD_LIMIT))
		else $error("decoded field out of range");

	// one request in flight: input closes after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	// the result is retired only after decode and scan, so no result right after a transaction
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_axis_tvalid && s_axis_tready) |-> !$rose(m_axis_tvalid))
		else $error("result appeared right after request");

	// register write never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind segment_alloc_access_checker sacc_chk u_sacc_chk (.*);
